/* rtl/dxtd_pkg.sv */
package dxtd_pkg;

  // Block formats on the command field; the unused code decodes as DXT1
  typedef enum logic [1:0] {
    CMD_DXT1 = 2'd0,
    CMD_DXT3 = 2'd1,
    CMD_DXT5 = 2'd2
  } dxtd_cmd_e;

  // Register index bit (byte address bit 2) of the only register
  localparam logic REG_FORCE_OPAQUE = 1'b0;

  // Reciprocal constants for exact floor division of alpha numerators
  localparam int unsigned DIV7_MUL   = 2341;  // ceil(2^14 / 7)
  localparam int unsigned DIV7_SHIFT = 14;
  localparam int unsigned DIV5_MUL   = 1639;  // ceil(2^13 / 5)
  localparam int unsigned DIV5_SHIFT = 13;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] endpoint_first;
    logic [15:0] endpoint_second;
    logic [31:0] color_selectors;
    logic [63:0] alpha_payload;
  } dxtd_in_t;

  typedef struct packed {
    logic [1:0]  row_number;
    logic [31:0] texel_zero;
    logic [31:0] texel_one;
    logic [31:0] texel_two;
    logic [31:0] texel_three;
    logic        last_row;
  } dxtd_out_t;

  // After the palette stage: color palette done, alpha numerators pending
  typedef struct packed {
    logic [1:0]        command;
    logic [31:0]       color_selectors;
    logic [63:0]       alpha_payload;
    logic [3:0][23:0]  pal_rgb;
    logic              pal3_clear;
    logic              eight_level;
    logic [5:0][10:0]  alpha_num;
  } dxtd_stage2_t;

  // Fully decoded block, ready for row output
  typedef struct packed {
    logic [1:0]       command;
    logic [31:0]      color_selectors;
    logic [63:0]      alpha_payload;
    logic [3:0][23:0] pal_rgb;
    logic             pal3_clear;
    logic [7:0][7:0]  alpha_pal;
  } dxtd_block_t;

endpackage

/* rtl/dxtd_palette.sv */
module dxtd_palette (
  input  dxtd_pkg::dxtd_in_t     blk_i,
  input  logic                   force_opaque_i,
  output dxtd_pkg::dxtd_stage2_t s2_o
);
  import dxtd_pkg::*;

  // Middle palette entries for one channel: {entry2, entry3}
  function automatic logic [15:0] mid_pair(logic [7:0] e1, logic [7:0] e2, logic four);
    logic signed [9:0] d;
    logic signed [9:0] t;
    logic [8:0]        sum;
    logic [15:0]       res;
    d   = signed'({2'b00, e2}) - signed'({2'b00, e1});
    t   = (d >>> 1) - (d >>> 3);
    sum = {1'b0, e1} + {1'b0, e2} + 9'd1;
    if (four) begin
      res = {e1 + t[7:0], e2 - t[7:0]};
    end else begin
      res = {sum[8:1], e2};
    end
    return res;
  endfunction

  logic [7:0]  r1, g1, b1, r2, g2, b2;
  logic        four;
  logic [15:0] mr, mg, mb;
  logic [7:0]  a1, a2;
  logic        eight;

  assign r1 = {blk_i.endpoint_first[4:0],   blk_i.endpoint_first[4:2]};
  assign g1 = {blk_i.endpoint_first[10:5],  blk_i.endpoint_first[10:9]};
  assign b1 = {blk_i.endpoint_first[15:11], blk_i.endpoint_first[15:13]};
  assign r2 = {blk_i.endpoint_second[4:0],   blk_i.endpoint_second[4:2]};
  assign g2 = {blk_i.endpoint_second[10:5],  blk_i.endpoint_second[10:9]};
  assign b2 = {blk_i.endpoint_second[15:11], blk_i.endpoint_second[15:13]};

  assign four = (blk_i.command == CMD_DXT3) || (blk_i.command == CMD_DXT5) ||
                (blk_i.endpoint_first > blk_i.endpoint_second) || force_opaque_i;

  assign mr = mid_pair(r1, r2, four);
  assign mg = mid_pair(g1, g2, four);
  assign mb = mid_pair(b1, b2, four);

  assign a1    = blk_i.alpha_payload[7:0];
  assign a2    = blk_i.alpha_payload[15:8];
  assign eight = a1 > a2;

  always_comb begin
    s2_o.command         = blk_i.command;
    s2_o.color_selectors = blk_i.color_selectors;
    s2_o.alpha_payload   = blk_i.alpha_payload;
    s2_o.pal_rgb[0]      = {r1, g1, b1};
    s2_o.pal_rgb[1]      = {r2, g2, b2};
    s2_o.pal_rgb[2]      = {mr[15:8], mg[15:8], mb[15:8]};
    s2_o.pal_rgb[3]      = {mr[7:0], mg[7:0], mb[7:0]};
    s2_o.pal3_clear      = !four;
    s2_o.eight_level     = eight;
    // Level j+2 weights: 8 levels (6-j, j+1) over 7; 6 levels (4-j, j+1) over 5
    for (int j = 0; j < 6; j++) begin
      if (eight) begin
        s2_o.alpha_num[j] = 11'(a1) * 11'(6 - j) + 11'(a2) * 11'(j + 1);
      end else if (j < 4) begin
        s2_o.alpha_num[j] = 11'(a1) * 11'(4 - j) + 11'(a2) * 11'(j + 1);
      end else begin
        s2_o.alpha_num[j] = '0;
      end
    end
  end

endmodule

/* rtl/dxtd_alpha_div.sv */
module dxtd_alpha_div (
  input  dxtd_pkg::dxtd_stage2_t s2_i,
  output dxtd_pkg::dxtd_block_t  blk_o
);
  import dxtd_pkg::*;

  logic [5:0][22:0] prod7;
  logic [5:0][22:0] prod5;

  always_comb begin
    blk_o.command         = s2_i.command;
    blk_o.color_selectors = s2_i.color_selectors;
    blk_o.alpha_payload   = s2_i.alpha_payload;
    blk_o.pal_rgb         = s2_i.pal_rgb;
    blk_o.pal3_clear      = s2_i.pal3_clear;
    blk_o.alpha_pal[0]    = s2_i.alpha_payload[7:0];
    blk_o.alpha_pal[1]    = s2_i.alpha_payload[15:8];
    for (int j = 0; j < 6; j++) begin
      // Floor division by 7 or 5 through a rounded-up reciprocal
      prod7[j] = {12'd0, s2_i.alpha_num[j]} * 23'(DIV7_MUL);
      prod5[j] = {12'd0, s2_i.alpha_num[j]} * 23'(DIV5_MUL);
      if (s2_i.eight_level) begin
        blk_o.alpha_pal[j + 2] = prod7[j][DIV7_SHIFT +: 8];
      end else if (j < 4) begin
        blk_o.alpha_pal[j + 2] = prod5[j][DIV5_SHIFT +: 8];
      end else if (j == 4) begin
        blk_o.alpha_pal[j + 2] = 8'd0;
      end else begin
        blk_o.alpha_pal[j + 2] = 8'd255;
      end
    end
  end

endmodule

/* rtl/dxtd_row_out.sv */
module dxtd_row_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  blk_valid_i,
  input  dxtd_pkg::dxtd_block_t blk_i,
  output logic                  blk_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dxtd_pkg::dxtd_out_t   out_data_o
);
  import dxtd_pkg::*;

  dxtd_block_t      blk_q;
  logic             have_q, have_d;
  logic [1:0]       row_q, row_d;
  logic             out_valid_q, out_valid_d;
  dxtd_out_t        out_q;
  dxtd_out_t        row_res;
  logic             adv, emit, last, load;
  logic [7:0]       sel_row;
  logic [15:0]      nib_row;
  logic [11:0]      idx_row;
  logic [3:0][31:0] tex;
  logic [1:0]       pi;
  logic [7:0]       a_col;
  logic [3:0]       nib;
  logic [2:0]       aidx;

  assign adv  = !out_valid_q || out_ready_i;
  assign emit = have_q && adv;
  assign last = (row_q == 2'd3);
  assign blk_ready_o = !have_q || (emit && last);
  assign load = blk_valid_i && blk_ready_o;

  assign sel_row = blk_q.color_selectors[{row_q, 3'b000} +: 8];
  assign nib_row = blk_q.alpha_payload[{row_q, 4'b0000} +: 16];

  always_comb begin
    case (row_q)
      2'd0:    idx_row = blk_q.alpha_payload[27:16];
      2'd1:    idx_row = blk_q.alpha_payload[39:28];
      2'd2:    idx_row = blk_q.alpha_payload[51:40];
      default: idx_row = blk_q.alpha_payload[63:52];
    endcase
  end

  always_comb begin
    tex = '0;
    pi = '0;
    a_col = '0;
    nib = '0;
    aidx = '0;
    for (int x = 0; x < 4; x++) begin
      pi    = sel_row[2 * x +: 2];
      a_col = (pi == 2'd3 && blk_q.pal3_clear) ? 8'd0 : 8'd255;
      nib   = nib_row[4 * x +: 4];
      aidx  = idx_row[3 * x +: 3];
      case (blk_q.command)
        CMD_DXT3: tex[x] = {nib, nib, blk_q.pal_rgb[pi]};
        CMD_DXT5: tex[x] = {blk_q.alpha_pal[aidx], blk_q.pal_rgb[pi]};
        default:  tex[x] = {a_col, blk_q.pal_rgb[pi]};
      endcase
    end
  end

  always_comb begin
    row_res.row_number  = row_q;
    row_res.texel_zero  = tex[0];
    row_res.texel_one   = tex[1];
    row_res.texel_two   = tex[2];
    row_res.texel_three = tex[3];
    row_res.last_row    = last;
  end

  always_comb begin
    have_d = have_q;
    row_d  = row_q;
    if (load) begin
      have_d = 1'b1;
      row_d  = 2'd0;
    end else if (emit) begin
      row_d = row_q + 2'd1;
      if (last) begin
        have_d = 1'b0;
      end
    end
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      row_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      have_q      <= have_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      blk_q <= blk_i;
    end
    if (emit) begin
      out_q <= row_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/dxt_block_texture_decoder.sv */
// DXT1/DXT3/DXT5 block decoder. Each accepted request is one compressed 4x4
// block; the block answers with four row results (row 0 first), each holding
// four 32-bit ARGB texels, with last_row set on row 3. The datapath is a
// four-stage pipeline: an input register, the palette stage (endpoint
// widening, four- or three-color middle entries, DXT5 alpha numerators),
// the alpha stage (exact floor division by 7 or 5 via reciprocal multiply),
// and a row unit that holds one decoded block and emits one row per cycle
// into the output register while the output is ready. The row unit sets the
// sustained rate: it loads the next block as it emits the last row of the
// current one; blocks queue in the earlier stages, so a new request is taken
// while earlier ones are still in flight. The first row of a block reaches
// the output through the input, palette, alpha, row and output registers.
// The single register force_opaque_palette (byte address 0) makes DXT1 blocks
// always decode in four-color mode; write it only while the decoder is idle.
module dxt_block_texture_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Block requests
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dxtd_pkg::dxtd_in_t  in_data_i,
  // Row results
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dxtd_pkg::dxtd_out_t out_data_o
);
  import dxtd_pkg::*;

  logic         force_q;
  logic         cfg_wr;

  logic         v1_q, v2_q, v3_q;
  dxtd_in_t     s1_q;
  dxtd_stage2_t s2_d, s2_q;
  dxtd_block_t  s3_d, s3_q;
  logic         rdy2, rdy3, blk_ready;

  // Config port: zero-wait, register at index 0 only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FORCE_OPAQUE);
  assign prdata = (paddr[2] == REG_FORCE_OPAQUE) ? {31'd0, force_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q <= 1'b0;
    end else if (cfg_wr) begin
      force_q <= pwdata[0];
    end
  end

  // Backpressure: a stage advances when it is empty or its successor takes it
  assign rdy3       = !v3_q || blk_ready;
  assign rdy2       = !v2_q || rdy3;
  assign in_ready_o = !v1_q || rdy2;

  dxtd_palette u_palette (
    .blk_i          (s1_q),
    .force_opaque_i (force_q),
    .s2_o           (s2_d)
  );

  dxtd_alpha_div u_alpha_div (
    .s2_i  (s2_q),
    .blk_o (s3_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Payload stages: load only when a valid request moves in
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (rdy2 && v1_q) begin
      s2_q <= s2_d;
    end
    if (rdy3 && v2_q) begin
      s3_q <= s3_d;
    end
  end

  // Hold one block and serialize its four rows
  dxtd_row_out u_row_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (v3_q),
    .blk_i       (s3_q),
    .blk_ready_o (blk_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/dxtd_checker.sv */
module dxtd_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  dxtd_pkg::dxtd_out_t out_data_o
);
  import dxtd_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("row result changed while stalled");

  // End-of-block flag marks row 3 only
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_row == (out_data_o.row_number == 2'd3)))
    else $error("last_row does not match row_number");

  // Register read back after write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == REG_FORCE_OPAQUE) |=>
      (paddr[2] != REG_FORCE_OPAQUE) || (prdata[0] == $past(pwdata[0])))
    else $error("force_opaque_palette readback mismatch");

  // Unused read bits are zero
  a_cfg_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> prdata[31:1] == 31'd0)
    else $error("reserved register bits read nonzero");

endmodule

bind dxt_block_texture_decoder dxtd_checker u_dxtd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import dxtd_pkg::*;

  // Command code outside the enum; the decoder treats it as DXT1
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Byte address of force_opaque_palette (register 0)
  localparam logic [2:0] ADDR_FORCE_OPAQUE = {REG_FORCE_OPAQUE, 2'b00};
  // Cycles without any accepted request or row before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // Cycles to let pass after the last row before idle-time actions
  localparam int DRAIN_CYCLES = 8;

  // One directed stimulus row; typed rows carry a uniform texel value
  typedef struct {
    dxtd_in_t    blk;
    bit          typed;
    logic [31:0] texel;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  dxtd_in_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  dxtd_out_t   out_data_o;

  // Side band that travels with each request: typed expectation or not
  logic        req_typed = 1'b0;
  logic [31:0] req_texel = '0;

  logic        opaque_cfg = 1'b0;   // mirror of force_opaque_palette
  bit          calm = 1'b0;         // no idling on either side when set
  int          mismatches = 0;
  int          stall_cycles = 0;
  dxtd_out_t   rows_pending[$];     // predicted rows, oldest first
  dir_row_t    dir_rows[$];

  dxt_block_texture_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Row predictor
  // ---------------------------------------------------------------------------

  // Widen 5- and 6-bit channels to 8 bits by replicating the top bits
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // Signed 3/8 of the endpoint difference, both shifts flooring
  function automatic int mid_step(input int e1, input int e2);
    int d;
    d = e2 - e1;
    return (d >>> 1) - (d >>> 3);
  endfunction

  function automatic logic [31:0] argb(input int a, input int r, input int g, input int b);
    return {a[7:0], r[7:0], g[7:0], b[7:0]};
  endfunction

  // Decode one block into its four rows and queue them
  function automatic void predict_rows(input dxtd_in_t blk, input logic opaque);
    int          r1, r2, g1, g2, b1, b2, tr, tg, tb, a1, a2, n, k;
    logic [31:0] pal[4];
    logic [7:0]  apal[8];
    logic [31:0] tex[4];
    logic [31:0] t;
    bit          four;
    dxtd_out_t   row;
    r1 = int'(widen5(blk.endpoint_first[4:0]));
    g1 = int'(widen6(blk.endpoint_first[10:5]));
    b1 = int'(widen5(blk.endpoint_first[15:11]));
    r2 = int'(widen5(blk.endpoint_second[4:0]));
    g2 = int'(widen6(blk.endpoint_second[10:5]));
    b2 = int'(widen5(blk.endpoint_second[15:11]));
    // DXT3/DXT5 always four-color; DXT1 (and the unused code) by endpoint order or the opaque setting
    four = (blk.command == CMD_DXT3) || (blk.command == CMD_DXT5) ||
           (blk.endpoint_first > blk.endpoint_second) || opaque;
    pal[0] = argb(255, r1, g1, b1);
    pal[1] = argb(255, r2, g2, b2);
    if (four) begin
      tr = mid_step(r1, r2);
      tg = mid_step(g1, g2);
      tb = mid_step(b1, b2);
      pal[2] = argb(255, r1 + tr, g1 + tg, b1 + tb);
      pal[3] = argb(255, r2 - tr, g2 - tg, b2 - tb);
    end else begin
      pal[2] = argb(255, (r1 + r2 + 1) / 2, (g1 + g2 + 1) / 2, (b1 + b2 + 1) / 2);
      pal[3] = argb(0, r2, g2, b2);
    end
    a1 = int'(blk.alpha_payload[7:0]);
    a2 = int'(blk.alpha_payload[15:8]);
    apal[0] = a1[7:0];
    apal[1] = a2[7:0];
    if (a1 > a2) begin
      for (n = 1; n <= 6; n++) apal[n + 1] = 8'(((7 - n) * a1 + n * a2) / 7);
    end else begin
      for (n = 1; n <= 4; n++) apal[n + 1] = 8'(((5 - n) * a1 + n * a2) / 5);
      apal[6] = 8'd0;
      apal[7] = 8'd255;
    end
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < 4; x++) begin
        k = y * 4 + x;
        t = pal[blk.color_selectors[2*k +: 2]];
        if (blk.command == CMD_DXT3) begin
          t[31:24] = 8'(17 * blk.alpha_payload[4*k +: 4]);
        end else if (blk.command == CMD_DXT5) begin
          t[31:24] = apal[blk.alpha_payload[16 + 3*k +: 3]];
        end
        tex[x] = t;
      end
      row.row_number  = y[1:0];
      row.texel_zero  = tex[0];
      row.texel_one   = tex[1];
      row.texel_two   = tex[2];
      row.texel_three = tex[3];
      row.last_row    = (y == 3);
      rows_pending.push_back(row);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Queue the expected rows for every accepted request. Typed requests use
  // the uniform texel from the directed table instead of the predictor.
  always @(posedge clk_i) begin : req_mon
    dxtd_out_t row;
    if (in_valid_i && in_ready_o) begin
      if (req_typed) begin
        for (int y = 0; y < 4; y++) begin
          row.row_number  = y[1:0];
          row.texel_zero  = req_texel;
          row.texel_one   = req_texel;
          row.texel_two   = req_texel;
          row.texel_three = req_texel;
          row.last_row    = (y == 3);
          rows_pending.push_back(row);
        end
      end else begin
        predict_rows(in_data_i, opaque_cfg);
      end
    end
  end

  // Compare each accepted row against the oldest prediction, field by field
  always @(posedge clk_i) begin : row_mon
    dxtd_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (rows_pending.size() == 0) begin
        report_mismatch("row with nothing pending", out_data_o.texel_zero, '0);
      end else begin
        want = rows_pending.pop_front();
        if (out_data_o.row_number !== want.row_number)
          report_mismatch("row_number", out_data_o.row_number, want.row_number);
        if (out_data_o.texel_zero !== want.texel_zero)
          report_mismatch("texel_zero", out_data_o.texel_zero, want.texel_zero);
        if (out_data_o.texel_one !== want.texel_one)
          report_mismatch("texel_one", out_data_o.texel_one, want.texel_one);
        if (out_data_o.texel_two !== want.texel_two)
          report_mismatch("texel_two", out_data_o.texel_two, want.texel_two);
        if (out_data_o.texel_three !== want.texel_three)
          report_mismatch("texel_three", out_data_o.texel_three, want.texel_three);
        if (out_data_o.last_row !== want.last_row)
          report_mismatch("last_row", out_data_o.last_row, want.last_row);
      end
    end
  end

  // Abandon the run when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("dxt_block_texture_decoder: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall in random bursts, never once calm is set
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic dir_row_t mk_row(input logic [1:0] cmd, input logic [15:0] e1,
                                      input logic [15:0] e2, input logic [31:0] sel,
                                      input logic [63:0] ap, input bit typed,
                                      input logic [31:0] texel);
    dir_row_t r;
    r.blk.command         = cmd;
    r.blk.endpoint_first  = e1;
    r.blk.endpoint_second = e2;
    r.blk.color_selectors = sel;
    r.blk.alpha_payload   = ap;
    r.typed = typed;
    r.texel = texel;
    return r;
  endfunction

  // Random block: mostly the three real formats, now and then the unused
  // code, equal endpoints or equal DXT5 alpha endpoints
  function automatic dxtd_in_t rand_block();
    dxtd_in_t b;
    int       pick;
    pick = $urandom_range(0, 15);
    if (pick < 5)       b.command = CMD_DXT1;
    else if (pick < 10) b.command = CMD_DXT3;
    else if (pick < 15) b.command = CMD_DXT5;
    else                b.command = CMD_UNUSED;
    b.endpoint_first  = 16'($urandom);
    b.endpoint_second = ($urandom_range(0, 7) == 0) ? b.endpoint_first : 16'($urandom);
    b.color_selectors = $urandom;
    b.alpha_payload   = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) b.alpha_payload[15:8] = b.alpha_payload[7:0];
    return b;
  endfunction

  // Present one request at the falling edge, maybe after an idle burst,
  // and hold it until the decoder takes it
  task automatic send_block(input dxtd_in_t blk, input bit typed, input logic [31:0] texel);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    req_typed  <= typed;
    req_texel  <= texel;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop the request line, drain, then write force_opaque_palette and read it back
  task automatic set_force_opaque(input logic value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    // write: setup, then access
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_FORCE_OPAQUE;
    pwdata  <= {31'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    opaque_cfg = value;
    // read back
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== value) report_mismatch("force_opaque_palette readback", prdata, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    // Directed rows. Typed ones are uniform blocks whose texel is obvious:
    // pure primaries, white, fully transparent three-color entries, the
    // extreme DXT3 nibbles and the fixed 0 and 255 levels of the DXT5
    // six-level palette. All of them assume force_opaque_palette = 0.
    dir_rows.push_back(mk_row(CMD_DXT1, 16'hFFFF, 16'h0000, 32'h0, 64'h0, 1, 32'hFFFFFFFF));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'h001F, 16'h0000, 32'h0, 64'h0, 1, 32'hFFFF0000));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'h07E0, 16'h0000, 32'h0, 64'h0, 1, 32'hFF00FF00));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'hF800, 16'h0000, 32'h0, 64'h0, 1, 32'hFF0000FF));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'h0000, 16'h0000, 32'hFFFFFFFF, 64'h0, 1, 32'h0));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'h0000, 16'hFFFF, 32'h55555555, '1, 1, 32'hFFFFFFFF));
    dir_rows.push_back(mk_row(CMD_DXT3, 16'hFFFF, 16'h0000, 32'h0, '1, 1, 32'hFFFFFFFF));
    dir_rows.push_back(mk_row(CMD_DXT3, 16'hFFFF, 16'h0000, 32'h0, 64'h0, 1, 32'h00FFFFFF));
    dir_rows.push_back(mk_row(CMD_DXT5, 16'hFFFF, 16'h0000, 32'h0, 64'h00FF, 1, 32'hFFFFFFFF));
    dir_rows.push_back(mk_row(CMD_DXT5, 16'hFFFF, 16'h0000, 32'h0,
                              {48'o6666666666666666, 16'h0}, 1, 32'h00FFFFFF));
    dir_rows.push_back(mk_row(CMD_DXT5, 16'hFFFF, 16'h0000, 32'h0,
                              {48'o7777777777777777, 16'h0}, 1, 32'hFFFFFFFF));
    dir_rows.push_back(mk_row(CMD_UNUSED, 16'hFFFF, 16'h0000, 32'h0, 64'h0, 1, 32'hFFFFFFFF));
    // Predicted rows: every palette entry in both color modes, endpoint ties
    // and near ties, DXT3/DXT5 forcing four-color, both DXT5 palettes with
    // every index, equal alpha endpoints, and the unused code as DXT1
    dir_rows.push_back(mk_row(CMD_DXT1, 16'hFFFF, 16'h0000, 32'hE4E4E4E4, 64'h0, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'h0000, 16'hFFFF, 32'hE4E4E4E4, 64'h0, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'h8410, 16'h8410, 32'h1B1B1B1B, 64'h0, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'h1234, 16'h1233, 32'hE4E4E4E4, 64'h0, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT1, 16'hABCD, 16'h5432, 32'h9C36D872, '1, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT3, 16'h0000, 16'hFFFF, 32'hE4E4E4E4,
                              64'h0123456789ABCDEF, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT5, 16'h07FF, 16'hF800, 32'hE4E4E4E4,
                              {48'o7654321076543210, 8'h10, 8'hF0}, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT5, 16'hF800, 16'h07FF, 32'h1B1B1B1B,
                              {48'o7654321076543210, 8'hF0, 8'h10}, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT5, 16'h5AA5, 16'hA55A, 32'hE4E4E4E4,
                              {48'o0123456701234567, 8'h80, 8'h80}, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT5, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF,
                              {48'o7654321076543210, 8'h00, 8'hFF}, 0, '0));
    dir_rows.push_back(mk_row(CMD_DXT5, 16'h0001, 16'h0000, 32'h0,
                              {48'o1111111122222222, 8'h00, 8'h01}, 0, '0));
    dir_rows.push_back(mk_row(CMD_UNUSED, 16'h0000, 16'hFFFF, 32'hE4E4E4E4, '1, 0, '0));

    // Hold reset low, then release it on a falling edge
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_force_opaque(1'b0);
    foreach (dir_rows[i]) send_block(dir_rows[i].blk, dir_rows[i].typed, dir_rows[i].texel);

    // Random phases across both register settings; the last one runs calm
    set_force_opaque(1'b1);
    repeat (150) send_block(rand_block(), 0, '0);
    set_force_opaque(1'b0);
    repeat (150) send_block(rand_block(), 0, '0);
    calm = 1'b1;
    set_force_opaque(1'b1);
    repeat (136) send_block(rand_block(), 0, '0);

    // Drop the request, wait for the last rows, then watch for strays
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (rows_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("dxt_block_texture_decoder: match");
    end else begin
      $display("dxt_block_texture_decoder: mismatch");
    end
    $finish;
  end

endmodule

/* dxt_block_texture_decoder.f */
rtl/dxtd_pkg.sv
rtl/dxtd_palette.sv
rtl/dxtd_alpha_div.sv
rtl/dxtd_row_out.sv
rtl/dxt_block_texture_decoder.sv
rtl/dxtd_checker.sv
tb/tb_top.sv
